// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker of the Hangul romanizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define HSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define HSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hsr_pkg.sv =====
// Package with types, constants and letter tables of the Hangul romanizer.
`timescale 1ns / 1ps

package hsr_pkg;

    // Default depth of the decoded item queue.
    localparam int unsigned HSR_FIFO_DEPTH = 8;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned MAX_CHARS = 7;

    // Syllable block bounds.
    localparam logic [20:0] SYL_FIRST = 21'h00AC00;
    localparam logic [20:0] SYL_LAST  = 21'h00D7A3;

    // Division by 588 as multiply by reciprocal, exact for offsets below 11172.
    localparam logic [13:0] LEAD_RECIP = 14'd14267;
    localparam int unsigned LEAD_SHIFT = 23;
    localparam logic [9:0]  LEAD_SPAN  = 10'd588;

    // Division by 28 as multiply by reciprocal, exact for remainders below 588.
    localparam logic [9:0]  VOWEL_RECIP = 10'd586;
    localparam int unsigned VOWEL_SHIFT = 14;
    localparam logic [4:0]  VOWEL_SPAN  = 5'd28;

    localparam logic [7:0] NUL = 8'h00;

    typedef logic [7:0] char_t;

    // Up to three letters of one table entry, c0 first.
    typedef struct packed {
        logic [1:0] len;
        char_t      c2;
        char_t      c1;
        char_t      c0;
    } letters_t;

    // One decoded input item, ready to serialize.
    typedef struct packed {
        logic                 hangul;
        logic [CP_W-1:0]      cp;
        logic [2:0]           last_idx;
        char_t [MAX_CHARS-1:0] chars;
    } item_t;

    function automatic letters_t mk(input logic [1:0] len, input char_t a,
                                    input char_t b, input char_t c);
        letters_t r;
        r.len = len;
        r.c0  = a;
        r.c1  = b;
        r.c2  = c;
        return r;
    endfunction

    function automatic char_t pick(input letters_t l, input logic [1:0] i);
        char_t r;
        unique case (i)
            2'd0:    r = l.c0;
            2'd1:    r = l.c1;
            2'd2:    r = l.c2;
            default: r = NUL;
        endcase
        return r;
    endfunction

    function automatic letters_t lead_letters(input logic [4:0] idx);
        letters_t r;
        unique case (idx)
            5'd0:    r = mk(2'd1, "g", NUL, NUL);
            5'd1:    r = mk(2'd2, "g", "g", NUL);
            5'd2:    r = mk(2'd1, "n", NUL, NUL);
            5'd3:    r = mk(2'd1, "d", NUL, NUL);
            5'd4:    r = mk(2'd2, "d", "d", NUL);
            5'd5:    r = mk(2'd1, "r", NUL, NUL);
            5'd6:    r = mk(2'd1, "m", NUL, NUL);
            5'd7:    r = mk(2'd1, "b", NUL, NUL);
            5'd8:    r = mk(2'd2, "b", "b", NUL);
            5'd9:    r = mk(2'd1, "s", NUL, NUL);
            5'd10:   r = mk(2'd2, "s", "s", NUL);
            5'd11:   r = mk(2'd0, NUL, NUL, NUL);
            5'd12:   r = mk(2'd1, "j", NUL, NUL);
            5'd13:   r = mk(2'd2, "j", "j", NUL);
            5'd14:   r = mk(2'd1, "c", NUL, NUL);
            5'd15:   r = mk(2'd1, "k", NUL, NUL);
            5'd16:   r = mk(2'd1, "t", NUL, NUL);
            5'd17:   r = mk(2'd1, "p", NUL, NUL);
            default: r = mk(2'd1, "h", NUL, NUL);
        endcase
        return r;
    endfunction

    function automatic letters_t vowel_letters(input logic [4:0] idx);
        letters_t r;
        unique case (idx)
            5'd0:    r = mk(2'd1, "a", NUL, NUL);
            5'd1:    r = mk(2'd2, "a", "e", NUL);
            5'd2:    r = mk(2'd2, "y", "a", NUL);
            5'd3:    r = mk(2'd3, "y", "a", "e");
            5'd4:    r = mk(2'd2, "e", "o", NUL);
            5'd5:    r = mk(2'd1, "e", NUL, NUL);
            5'd6:    r = mk(2'd3, "y", "e", "o");
            5'd7:    r = mk(2'd2, "y", "e", NUL);
            5'd8:    r = mk(2'd1, "o", NUL, NUL);
            5'd9:    r = mk(2'd2, "w", "a", NUL);
            5'd10:   r = mk(2'd3, "w", "a", "e");
            5'd11:   r = mk(2'd2, "o", "e", NUL);
            5'd12:   r = mk(2'd2, "y", "o", NUL);
            5'd13:   r = mk(2'd1, "u", NUL, NUL);
            5'd14:   r = mk(2'd3, "w", "e", "o");
            5'd15:   r = mk(2'd2, "w", "e", NUL);
            5'd16:   r = mk(2'd2, "w", "i", NUL);
            5'd17:   r = mk(2'd2, "y", "u", NUL);
            5'd18:   r = mk(2'd2, "e", "u", NUL);
            5'd19:   r = mk(2'd3, "e", "u", "i");
            default: r = mk(2'd1, "i", NUL, NUL);
        endcase
        return r;
    endfunction

    function automatic letters_t final_letters(input logic [4:0] idx);
        letters_t r;
        unique case (idx)
            5'd0:    r = mk(2'd0, NUL, NUL, NUL);
            5'd1:    r = mk(2'd1, "g", NUL, NUL);
            5'd2:    r = mk(2'd2, "g", "g", NUL);
            5'd3:    r = mk(2'd2, "g", "s", NUL);
            5'd4:    r = mk(2'd1, "n", NUL, NUL);
            5'd5:    r = mk(2'd2, "n", "j", NUL);
            5'd6:    r = mk(2'd2, "n", "h", NUL);
            5'd7:    r = mk(2'd1, "d", NUL, NUL);
            5'd8:    r = mk(2'd1, "r", NUL, NUL);
            5'd9:    r = mk(2'd2, "r", "k", NUL);
            5'd10:   r = mk(2'd2, "r", "m", NUL);
            5'd11:   r = mk(2'd2, "r", "b", NUL);
            5'd12:   r = mk(2'd2, "r", "s", NUL);
            5'd13:   r = mk(2'd2, "r", "t", NUL);
            5'd14:   r = mk(2'd2, "r", "p", NUL);
            5'd15:   r = mk(2'd2, "r", "h", NUL);
            5'd16:   r = mk(2'd1, "m", NUL, NUL);
            5'd17:   r = mk(2'd1, "b", NUL, NUL);
            5'd18:   r = mk(2'd2, "b", "s", NUL);
            5'd19:   r = mk(2'd1, "s", NUL, NUL);
            5'd20:   r = mk(2'd2, "s", "s", NUL);
            5'd21:   r = mk(2'd2, "n", "g", NUL);
            5'd22:   r = mk(2'd1, "j", NUL, NUL);
            5'd23:   r = mk(2'd1, "c", NUL, NUL);
            5'd24:   r = mk(2'd1, "k", NUL, NUL);
            5'd25:   r = mk(2'd1, "t", NUL, NUL);
            5'd26:   r = mk(2'd1, "p", NUL, NUL);
            default: r = mk(2'd1, "h", NUL, NUL);
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/hsr_decomp.sv =====
// Five-stage pipeline that splits a syllable into letter runs.
`timescale 1ns / 1ps

module hsr_decomp
    import hsr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [CP_W-1:0] code_point,
    output logic            item_valid,
    output item_t           item
);

    // Stage registers.
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic            s1_hangul_reg, s2_hangul_reg, s3_hangul_reg, s4_hangul_reg;
    logic [CP_W-1:0] s1_cp_reg, s2_cp_reg, s3_cp_reg, s4_cp_reg;
    logic [13:0]     s1_off_reg, s2_off_reg;
    logic [4:0]      s2_lead_reg, s3_lead_reg, s4_lead_reg;
    logic [9:0]      s3_rem_reg, s4_rem_reg;
    logic [4:0]      s4_vowel_reg;
    item_t           s5_item_reg;

    // Next values.
    logic            s1_hangul_next;
    logic [13:0]     s1_off_next;
    logic [27:0]     lead_prod;
    logic [4:0]      s2_lead_next;
    logic [13:0]     lead_base;
    logic [9:0]      s3_rem_next;
    logic [19:0]     vowel_prod;
    logic [4:0]      s4_vowel_next;
    logic [9:0]      vowel_base;
    logic [4:0]      fin_idx;
    item_t           s5_item_next;

    // Range check and offset.
    assign s1_hangul_next = (code_point >= SYL_FIRST) && (code_point <= SYL_LAST);
    assign s1_off_next    = 14'(code_point - SYL_FIRST);

    // Lead index by reciprocal multiply.
    assign lead_prod    = 28'(s1_off_reg) * 28'(LEAD_RECIP);
    assign s2_lead_next = 5'(lead_prod >> LEAD_SHIFT);

    // Remainder after the lead.
    assign lead_base   = 14'(s2_lead_reg) * 14'(LEAD_SPAN);
    assign s3_rem_next = 10'(s2_off_reg - lead_base);

    // Vowel index by reciprocal multiply.
    assign vowel_prod    = 20'(s3_rem_reg) * 20'(VOWEL_RECIP);
    assign s4_vowel_next = 5'(vowel_prod >> VOWEL_SHIFT);

    // Final index, table lookup and packing of the letter run.
    assign vowel_base = 10'(s4_vowel_reg) * 10'(VOWEL_SPAN);
    assign fin_idx    = 5'(s4_rem_reg - vowel_base);

    always_comb
    begin
        letters_t   ll;
        letters_t   vl;
        letters_t   fl;
        logic [2:0] llen;
        logic [2:0] lvlen;
        logic [2:0] total;
        logic [2:0] kk;
        ll    = lead_letters(s4_lead_reg);
        vl    = vowel_letters(s4_vowel_reg);
        fl    = final_letters(fin_idx);
        llen  = 3'(ll.len);
        lvlen = llen + 3'(vl.len);
        total = lvlen + 3'(fl.len);
        s5_item_next.hangul = s4_hangul_reg;
        for (int k = 0; k < MAX_CHARS; k++)
        begin
            kk = 3'(k);
            if (!s4_hangul_reg)
                s5_item_next.chars[k] = NUL;
            else if (kk < llen)
                s5_item_next.chars[k] = pick(ll, 2'(kk));
            else if (kk < lvlen)
                s5_item_next.chars[k] = pick(vl, 2'(kk - llen));
            else
                s5_item_next.chars[k] = pick(fl, 2'(kk - lvlen));
        end
        if (s4_hangul_reg)
        begin
            s5_item_next.cp       = '0;
            s5_item_next.last_idx = total - 3'd1;
        end
        else
        begin
            s5_item_next.cp       = s4_cp_reg;
            s5_item_next.last_idx = 3'd0;
        end
    end

    // Advance valid bits every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Advance payload every cycle.
    always_ff @(posedge clk)
    begin
        s1_hangul_reg <= s1_hangul_next;
        s1_cp_reg     <= code_point;
        s1_off_reg    <= s1_off_next;

        s2_hangul_reg <= s1_hangul_reg;
        s2_cp_reg     <= s1_cp_reg;
        s2_off_reg    <= s1_off_reg;
        s2_lead_reg   <= s2_lead_next;

        s3_hangul_reg <= s2_hangul_reg;
        s3_cp_reg     <= s2_cp_reg;
        s3_lead_reg   <= s2_lead_reg;
        s3_rem_reg    <= s3_rem_next;

        s4_hangul_reg <= s3_hangul_reg;
        s4_cp_reg     <= s3_cp_reg;
        s4_lead_reg   <= s3_lead_reg;
        s4_rem_reg    <= s3_rem_reg;
        s4_vowel_reg  <= s4_vowel_next;

        s5_item_reg   <= s5_item_next;
    end

    assign item_valid = s5_valid_reg;
    assign item       = s5_item_reg;

endmodule

// ===== hdl/hangul_syllable_romanizer_core.sv =====
// Top level of the Hangul syllable romanizer: decode pipeline, item queue, serializer.
`timescale 1ns / 1ps

// A beat passes the decode stages, the item queue and the result registers to the ports.
// One result per cycle while an item is queued; a syllable gives 1 to 7 results,
// and any other code point 1. Busy rises when FIFO_DEPTH items are in flight or queued.
// The serializer sends one letter of the head item per cycle and sets the sustained rate.
// Reset clears valid bits, queue pointers and counters; payload registers are not reset.

module hangul_syllable_romanizer_core
    import hsr_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = HSR_FIFO_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [CP_W-1:0] code_point,
    output logic            strobe,
    output logic [7:0]      out_char,
    output logic            hangul_flag,
    output logic [CP_W-1:0] passthrough_point,
    output logic            last_of_run
);

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    logic            accept;
    logic            dec_valid;
    item_t           dec_item;

    item_t           fifo_mem [FIFO_DEPTH];
    item_t           head;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic            busy_reg, busy_next;
    logic            head_valid;
    logic            pop;
    logic [2:0]      idx_reg, idx_next;

    logic            strobe_reg;
    logic [7:0]      out_char_reg;
    logic            hangul_flag_reg;
    logic [CP_W-1:0] passthrough_point_reg;
    logic            last_of_run_reg;

    assign accept = start && !busy_reg;

    hsr_decomp u_decomp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .code_point (code_point),
        .item_valid (dec_valid),
        .item       (dec_item)
    );

    // Serialize the head item one letter per cycle.
    assign head       = fifo_mem[rd_ptr_reg];
    assign head_valid = (fifo_cnt_reg != '0);
    assign pop        = head_valid && (idx_reg == head.last_idx);

    always_comb
    begin
        if (!head_valid)
            idx_next = idx_reg;
        else if (pop)
            idx_next = 3'd0;
        else
            idx_next = idx_reg + 3'd1;
    end

    // Advance queue pointers and counters; pending covers the pipeline and the queue.
    assign wr_ptr_next = !dec_valid ? wr_ptr_reg :
                         (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !pop ? rd_ptr_reg :
                         (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign fifo_cnt_next = fifo_cnt_reg + CNT_W'(dec_valid) - CNT_W'(pop);
    assign pending_next  = pending_reg + CNT_W'(accept) - CNT_W'(pop);
    assign busy_next     = (pending_next == CNT_W'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pending_reg  <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= 3'd0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
            pending_reg  <= pending_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            strobe_reg   <= head_valid;
        end
    end

    // Hold decoded items in the queue.
    always_ff @(posedge clk)
    begin
        if (dec_valid)
            fifo_mem[wr_ptr_reg] <= dec_item;
    end

    // Load the result registers.
    always_ff @(posedge clk)
    begin
        if (head_valid)
        begin
            out_char_reg          <= head.chars[idx_reg];
            hangul_flag_reg       <= head.hangul;
            passthrough_point_reg <= head.cp;
            last_of_run_reg       <= pop;
        end
    end

    assign busy              = busy_reg;
    assign strobe            = strobe_reg;
    assign out_char          = out_char_reg;
    assign hangul_flag       = hangul_flag_reg;
    assign passthrough_point = passthrough_point_reg;
    assign last_of_run       = last_of_run_reg;

endmodule

// ===== hdl/hsr_checker.sv =====
// Port-level checker of the Hangul romanizer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsr_checker
    import hsr_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic [CP_W-1:0] code_point,
    input logic            strobe,
    input logic [7:0]      out_char,
    input logic            hangul_flag,
    input logic [CP_W-1:0] passthrough_point,
    input logic            last_of_run
);

    // A non-syllable beat is a single result with no letter.
    `HSR_ASSERT_NOW(a_plain_single, strobe && !hangul_flag, last_of_run && out_char == 8'h00, "non-syllable result malformed")

    // A syllable result carries a lower-case letter and no echoed code point.
    `HSR_ASSERT_NOW(a_hangul_letter, strobe && hangul_flag, passthrough_point == 21'h0 && out_char >= 8'h61 && out_char <= 8'h7a, "syllable result malformed")

    // A run that is not finished continues in the next cycle.
    `HSR_ASSERT_NEXT(a_run_continues, strobe && !last_of_run, strobe && hangul_flag, "letter run broken")

    // Busy rises only after a beat was taken.
    `HSR_ASSERT_NOW(a_busy_after_accept, $rose(busy), $past(start && !busy), "busy rose without a beat")

endmodule

bind hangul_syllable_romanizer_core hsr_checker u_hsr_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench of the Hangul syllable romanizer core: directed and random code points.
`timescale 1ns / 1ps

module tb;
    import hsr_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int LEAD_STRIDE  = 588;
    localparam int VOWEL_STRIDE = 28;
    localparam int NUM_RANDOM   = 289;
    localparam int IDLE_PERCENT = 26;
    localparam int CALM_FIRST   = 120;
    localparam int CALM_LAST    = 200;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int NUM_DIRECTED = 21;

    // One result beat as it should appear on the ports.
    typedef struct {
        logic [7:0]      ch;
        logic            hangul;
        logic [CP_W-1:0] cp;
        logic            last;
    } char_beat_t;

    // One directed row; typed rows carry their letters, the rest go through the predictor.
    typedef struct {
        logic [CP_W-1:0] cp;
        bit              typed;
        bit              hangul;
        string           text;
    } directed_row_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            start      = 1'b0;
    logic [CP_W-1:0] code_point = '0;
    logic            busy;
    logic            strobe;
    logic [7:0]      out_char;
    logic            hangul_flag;
    logic [CP_W-1:0] passthrough_point;
    logic            last_of_run;

    char_beat_t romanized_q[$];
    int         err_count   = 0;
    int         cycle_count = 0;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{21'h000000, 1'b1, 1'b0, ""},     // lowest code point
        '{21'h1FFFFF, 1'b1, 1'b0, ""},     // all ones, beyond the Unicode range
        '{21'h10FFFF, 1'b1, 1'b0, ""},     // highest scalar value
        '{21'h110000, 1'b1, 1'b0, ""},     // just above the Unicode range
        '{21'h00ABFF, 1'b1, 1'b0, ""},     // just below the syllable block
        '{21'h00D7A4, 1'b1, 1'b0, ""},     // just above the syllable block
        '{21'h00AC00, 1'b1, 1'b1, "ga"},   // first syllable
        '{21'h00D7A3, 1'b1, 1'b1, "hih"},  // last syllable
        '{21'h00C544, 1'b1, 1'b1, "a"},    // silent lead, no final: one beat
        '{21'h00C482, 1'b0, 1'b0, ""},     // seven letters
        '{21'h00AC01, 1'b0, 1'b0, ""},
        '{21'h00AC1B, 1'b0, 1'b0, ""},     // highest final index
        '{21'h00C54F, 1'b0, 1'b0, ""},     // silent lead with a final
        '{21'h00AE4B, 1'b0, 1'b0, ""},     // last syllable of the first lead
        '{21'h00AE4C, 1'b0, 1'b0, ""},     // first syllable of the second lead
        '{21'h000041, 1'b0, 1'b0, ""},
        '{21'h00FFFF, 1'b0, 1'b0, ""},
        '{21'h01F600, 1'b0, 1'b0, ""},
        '{21'h0AAAAA, 1'b0, 1'b0, ""},
        '{21'h155555, 1'b0, 1'b0, ""},
        '{21'h00B18C, 1'b0, 1'b0, ""}
    };

    hangul_syllable_romanizer_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .code_point        (code_point),
        .strobe            (strobe),
        .out_char          (out_char),
        .hangul_flag       (hangul_flag),
        .passthrough_point (passthrough_point),
        .last_of_run       (last_of_run)
    );

    always #1 clk = ~clk;

    // Letter tables; the silent lead and the empty final fall to the default.
    function automatic string lead_text(input int idx);
        case (idx)
            0:  return "g";   1:  return "gg";  2:  return "n";   3:  return "d";
            4:  return "dd";  5:  return "r";   6:  return "m";   7:  return "b";
            8:  return "bb";  9:  return "s";   10: return "ss";  12: return "j";
            13: return "jj";  14: return "c";   15: return "k";   16: return "t";
            17: return "p";   18: return "h";
            default: return "";
        endcase
    endfunction

    function automatic string vowel_text(input int idx);
        case (idx)
            0:  return "a";   1:  return "ae";  2:  return "ya";  3:  return "yae";
            4:  return "eo";  5:  return "e";   6:  return "yeo"; 7:  return "ye";
            8:  return "o";   9:  return "wa";  10: return "wae"; 11: return "oe";
            12: return "yo";  13: return "u";   14: return "weo"; 15: return "we";
            16: return "wi";  17: return "yu";  18: return "eu";  19: return "eui";
            default: return "i";
        endcase
    endfunction

    function automatic string final_text(input int idx);
        case (idx)
            1:  return "g";   2:  return "gg";  3:  return "gs";  4:  return "n";
            5:  return "nj";  6:  return "nh";  7:  return "d";   8:  return "r";
            9:  return "rk";  10: return "rm";  11: return "rb";  12: return "rs";
            13: return "rt";  14: return "rp";  15: return "rh";  16: return "m";
            17: return "b";   18: return "bs";  19: return "s";   20: return "ss";
            21: return "ng";  22: return "j";   23: return "c";   24: return "k";
            25: return "t";   26: return "p";   27: return "h";
            default: return "";
        endcase
    endfunction

    function automatic bit is_syllable(input logic [CP_W-1:0] cp);
        return cp >= SYL_FIRST && cp <= SYL_LAST;
    endfunction

    // Split the syllable offset into lead, vowel and final and spell them out.
    function automatic string romanize_point(input logic [CP_W-1:0] cp);
        int offset;
        offset = int'(cp - SYL_FIRST);
        return {lead_text(offset / LEAD_STRIDE),
                vowel_text((offset % LEAD_STRIDE) / VOWEL_STRIDE),
                final_text(offset % VOWEL_STRIDE)};
    endfunction

    // Queue the beats of one accepted code point: letters, or one pass-through beat.
    function automatic void queue_letters(input logic [CP_W-1:0] cp, input bit hangul,
                                          input string text);
        char_beat_t beat;
        if (!hangul) begin
            beat = '{8'h00, 1'b0, cp, 1'b1};
            romanized_q.push_back(beat);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                beat = '{8'(text[i]), 1'b1, '0, (i == text.len() - 1)};
                romanized_q.push_back(beat);
            end
        end
    endfunction

    function automatic void predict_point(input logic [CP_W-1:0] cp);
        if (is_syllable(cp))
            queue_letters(cp, 1'b1, romanize_point(cp));
        else
            queue_letters(cp, 1'b0, "");
    endfunction

    // Mostly syllables, some around the block edges, the rest anywhere in 21 bits.
    function automatic logic [CP_W-1:0] pick_point();
        logic [CP_W-1:0] cp;
        int unsigned     roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            cp = CP_W'($urandom_range(SYL_FIRST, SYL_LAST));
        else if (roll < 80)
            cp = CP_W'($urandom_range(0, 1) ? $urandom_range(SYL_FIRST - 16, SYL_FIRST + 15)
                                            : $urandom_range(SYL_LAST - 15, SYL_LAST + 16));
        else
            cp = CP_W'($urandom_range(0, 21'h1FFFFF));
        return cp;
    endfunction

    // Raise start with the code point and hold until the beat is taken.
    task automatic send_point(input logic [CP_W-1:0] cp);
        start      <= 1'b1;
        code_point <= cp;
        do @(posedge clk); while (busy);
    endtask

    // Drop start now and then, with noise on the idle bus.
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start      <= 1'b0;
            code_point <= CP_W'($urandom_range(0, 21'h1FFFFF));
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    initial begin : drive_points
        logic [CP_W-1:0] cp;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (directed_rows[r]) begin
            send_point(directed_rows[r].cp);
            if (directed_rows[r].typed)
                queue_letters(directed_rows[r].cp, directed_rows[r].hangul,
                              directed_rows[r].text);
            else
                predict_point(directed_rows[r].cp);
            maybe_idle(1'b1);
        end

        // Random code points, with one stretch at full rate.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            cp = pick_point();
            send_point(cp);
            predict_point(cp);
            maybe_idle(n < CALM_FIRST || n >= CALM_LAST);
        end
        start <= 1'b0;

        // Drain the outstanding beats, then watch for strays.
        while (romanized_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Compare each result beat with the oldest expected one.
    always @(posedge clk) begin : check_beats
        char_beat_t want;
        if (rst_n && strobe) begin
            if (romanized_q.size() == 0) begin
                $display("%0t: unexpected beat: char=%h flag=%b point=%h last=%b",
                         $time, out_char, hangul_flag, passthrough_point, last_of_run);
                err_count++;
            end else begin
                want = romanized_q.pop_front();
                if (out_char !== want.ch || hangul_flag !== want.hangul ||
                    passthrough_point !== want.cp || last_of_run !== want.last) begin
                    $display("%0t: mismatch: expected char=%h flag=%b point=%h last=%b,",
                             $time, want.ch, want.hangul, want.cp, want.last);
                    $display("%0t:           actual   char=%h flag=%b point=%h last=%b",
                             $time, out_char, hangul_flag, passthrough_point, last_of_run);
                    err_count++;
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
